### src/pidc_pkg.sv
package pidc_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 16;
    localparam int INT_W     = 64;
    localparam int HALF_W    = INT_W / 2;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = INT_W + DATA_W;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 4;
    localparam int DIV_CNT_W = $clog2(DIFF_W + 1);

    localparam logic [TIME_W-1:0] STEP_TIME_RESET = TIME_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_TARGET      = 3'd3,
        REG_FLOOR       = 3'd4,
        REG_CEILING     = 3'd5,
        REG_SAMPLE      = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        MS_ERR_DT = 3'd0,
        MS_P_ERR  = 3'd1,
        MS_I_LO   = 3'd2,
        MS_I_HI   = 3'd3,
        MS_D_DER  = 3'd4
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD    = 2'd2,
        ACC_ADD_HI = 2'd3
    } acc_op_t;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_ERR     = 3'd1,
        OP_DIFF    = 3'd2,
        OP_INTEG   = 3'd3,
        OP_DERIV   = 3'd4,
        OP_SAT     = 3'd5,
        OP_CLAMP   = 3'd6,
        OP_PUBLISH = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        C_ALWAYS   = 2'd0,
        C_DIV_DONE = 2'd1,
        C_OUT_FREE = 2'd2
    } cond_t;

    typedef struct packed {
        mul_sel_t        mul_sel;
        acc_op_t         acc_op;
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctl_t;

    localparam logic [PC_W-1:0] PC_FIRST   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_PUBLISH = PC_W'(11);

    // Control store: the step advances to target once its condition holds
    function automatic ctl_t pidc_ucode(input logic [PC_W-1:0] pc);
        ctl_t cw;
        unique case (pc)
            PC_W'(0):  cw = '{MS_ERR_DT, ACC_HOLD,   OP_ERR,     C_ALWAYS,   PC_W'(1)};
            PC_W'(1):  cw = '{MS_ERR_DT, ACC_HOLD,   OP_DIFF,    C_ALWAYS,   PC_W'(2)};
            PC_W'(2):  cw = '{MS_P_ERR,  ACC_HOLD,   OP_INTEG,   C_ALWAYS,   PC_W'(3)};
            PC_W'(3):  cw = '{MS_I_LO,   ACC_LOAD,   OP_NONE,    C_ALWAYS,   PC_W'(4)};
            PC_W'(4):  cw = '{MS_I_HI,   ACC_ADD,    OP_NONE,    C_ALWAYS,   PC_W'(5)};
            PC_W'(5):  cw = '{MS_I_HI,   ACC_ADD_HI, OP_NONE,    C_ALWAYS,   PC_W'(6)};
            PC_W'(6):  cw = '{MS_D_DER,  ACC_HOLD,   OP_DERIV,   C_DIV_DONE, PC_W'(7)};
            PC_W'(7):  cw = '{MS_D_DER,  ACC_HOLD,   OP_NONE,    C_ALWAYS,   PC_W'(8)};
            PC_W'(8):  cw = '{MS_D_DER,  ACC_ADD,    OP_NONE,    C_ALWAYS,   PC_W'(9)};
            PC_W'(9):  cw = '{MS_D_DER,  ACC_HOLD,   OP_SAT,     C_ALWAYS,   PC_W'(10)};
            PC_W'(10): cw = '{MS_D_DER,  ACC_HOLD,   OP_CLAMP,   C_ALWAYS,   PC_PUBLISH};
            PC_W'(11): cw = '{MS_D_DER,  ACC_HOLD,   OP_PUBLISH, C_OUT_FREE, PC_FIRST};
            default:   cw = '{MS_D_DER,  ACC_HOLD,   OP_PUBLISH, C_OUT_FREE, PC_FIRST};
        endcase
        return cw;
    endfunction

endpackage

### src/pid_controller_clamped.sv
// Clamped PID controller, Q16.16, run by a twelve-step control store.
// An update runs every step of the control store, with the derivative in the bit-serial
// divider; a skipped item goes straight to the publish step.
// Throughput: one item at a time, in_ready returns the cycle after publish, and publish
// waits while out_ready holds back the previous result.
// Reset: rst_n clears control, gains, setpoint and state at once; floor and ceiling
// go to the full range, sample period and step time to 100 ms. No clearing pass.
module pid_controller_clamped (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidc_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pidc_pkg::DATA_W-1:0]  measurement,
    input  logic [pidc_pkg::TIME_W-1:0]         elapsed_ms,
    input  logic                                mode,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                updated,
    output logic signed [pidc_pkg::DATA_W-1:0]  drive_out,
    output logic signed [pidc_pkg::DATA_W-1:0]  error_out,
    output logic signed [pidc_pkg::INT_W-1:0]   integral_out,
    output logic signed [pidc_pkg::DATA_W-1:0]  derivative_out
);
    import pidc_pkg::*;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DIFF_W:0] v);
        logic same;
        same = (&v[DIFF_W:DATA_W-1]) || !(|v[DIFF_W:DATA_W-1]);
        if (same)
            return v[DATA_W-1:0];
        else if (v[DIFF_W])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    // configuration
    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, target_reg;
    logic signed [DATA_W-1:0] floor_reg, ceiling_reg;
    logic [TIME_W-1:0]        sample_period_reg;

    // controller state
    logic signed [DATA_W-1:0] last_error_reg, last_deriv_reg, last_drive_reg;
    logic signed [INT_W-1:0]  integral_reg;
    logic [TIME_W-1:0]        step_time_reg;

    // sequencer and datapath
    logic                     running_reg;
    logic [PC_W-1:0]          pc_reg;
    logic                     upd_pend_reg;
    logic signed [DATA_W-1:0] meas_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic                     diff_neg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [INT_W-1:0]  drive64_reg;

    // output register
    logic                     out_valid_reg;
    logic                     out_upd_reg;
    logic signed [DATA_W-1:0] out_drive_reg, out_error_reg, out_deriv_reg;
    logic signed [INT_W-1:0]  out_integral_reg;

    ctl_t                     cw;
    logic                     cond_ok;
    logic                     exec;
    logic                     in_xfer;
    logic                     go;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [DIFF_W:0]   err_wide;
    logic signed [DIFF_W-1:0] diff_c;
    logic [DIFF_W-1:0]        diff_mag;
    logic                     div_start;
    logic                     div_done;
    logic [DIFF_W-1:0]        div_quo;
    logic signed [DIFF_W:0]   q_wide;
    logic signed [INT_W:0]    int_wide;
    logic signed [INT_W-1:0]  int_next;
    logic signed [ACC_W-1:0]  acc_shift;
    logic signed [INT_W-1:0]  drive64_next;
    logic signed [INT_W-1:0]  ceil64, floor64;

    assign cw       = pidc_ucode(pc_reg);
    assign in_ready = !running_reg;
    assign in_xfer  = in_valid && in_ready;
    assign go       = mode || (elapsed_ms >= sample_period_reg);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        unique case (cw.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_DIV_DONE: cond_ok = div_done;
            C_OUT_FREE: cond_ok = !out_valid_reg || out_ready;
            default:    cond_ok = 1'b1;
        endcase
    end

    assign exec = running_reg && cond_ok;

    always_comb
    begin
        unique case (cw.mul_sel)
            MS_ERR_DT:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({{(MUL_W-TIME_W){1'b0}}, step_time_reg});
            end
            MS_P_ERR:
            begin
                mul_a = MUL_W'(gain_p_reg);
                mul_b = MUL_W'(err_reg);
            end
            MS_I_LO:
            begin
                mul_a = MUL_W'(gain_i_reg);
                mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, integral_reg[HALF_W-1:0]});
            end
            MS_I_HI:
            begin
                mul_a = MUL_W'(gain_i_reg);
                mul_b = MUL_W'($signed(integral_reg[INT_W-1:HALF_W]));
            end
            default:
            begin
                mul_a = MUL_W'(gain_d_reg);
                mul_b = MUL_W'(last_deriv_reg);
            end
        endcase
    end

    assign err_wide = (DIFF_W+1)'(target_reg) - (DIFF_W+1)'(meas_reg);
    assign diff_c   = DIFF_W'(err_reg) - DIFF_W'(last_error_reg);
    assign diff_mag = diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
    assign div_start = running_reg && (cw.op == OP_DIFF);
    assign q_wide   = diff_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    assign int_wide = (INT_W+1)'(integral_reg) + (INT_W+1)'(prod_reg);
    always_comb
    begin
        if (int_wide[INT_W] != int_wide[INT_W-1])
            int_next = int_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                       : {1'b0, {(INT_W-1){1'b1}}};
        else
            int_next = int_wide[INT_W-1:0];
    end

    // floor shift of the exact sum, then saturate to the integral width
    assign acc_shift = acc_reg >>> FRAC_BITS;
    always_comb
    begin
        if ((&acc_shift[ACC_W-1:INT_W-1]) || !(|acc_shift[ACC_W-1:INT_W-1]))
            drive64_next = acc_shift[INT_W-1:0];
        else if (acc_shift[ACC_W-1])
            drive64_next = {1'b1, {(INT_W-1){1'b0}}};
        else
            drive64_next = {1'b0, {(INT_W-1){1'b1}}};
    end

    assign ceil64  = INT_W'(ceiling_reg);
    assign floor64 = INT_W'(floor_reg);

    pidc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag),
        .divisor  (step_time_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= '0;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            target_reg        <= '0;
            floor_reg         <= {1'b1, {(DATA_W-1){1'b0}}};
            ceiling_reg       <= {1'b0, {(DATA_W-1){1'b1}}};
            sample_period_reg <= STEP_TIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_P:  gain_p_reg  <= cfg_data;
                REG_GAIN_I:  gain_i_reg  <= cfg_data;
                REG_GAIN_D:  gain_d_reg  <= cfg_data;
                REG_TARGET:  target_reg  <= cfg_data;
                REG_FLOOR:   floor_reg   <= cfg_data;
                REG_CEILING: ceiling_reg <= cfg_data;
                REG_SAMPLE:
                begin
                    // drop zero periods
                    if (cfg_data[TIME_W-1:0] != '0)
                        sample_period_reg <= cfg_data[TIME_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // sequencer control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            pc_reg         <= PC_FIRST;
            upd_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            last_deriv_reg <= '0;
            last_drive_reg <= '0;
            integral_reg   <= '0;
            step_time_reg  <= STEP_TIME_RESET;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (in_xfer)
            begin
                running_reg  <= 1'b1;
                upd_pend_reg <= go;
                pc_reg       <= go ? PC_FIRST : PC_PUBLISH;
                if (!mode && go)
                    step_time_reg <= elapsed_ms;
            end
            else if (exec)
            begin
                pc_reg <= cw.target;
                case (cw.op)
                    OP_INTEG: integral_reg <= int_next;
                    OP_DERIV:
                    begin
                        last_deriv_reg <= sat_data(q_wide);
                        last_error_reg <= err_reg;
                    end
                    OP_CLAMP:
                    begin
                        if (drive64_reg > ceil64)
                            last_drive_reg <= ceiling_reg;
                        else if (drive64_reg < floor64)
                            last_drive_reg <= floor_reg;
                        else
                            last_drive_reg <= drive64_reg[DATA_W-1:0];
                    end
                    OP_PUBLISH:
                    begin
                        running_reg   <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            meas_reg <= measurement;

        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);

        if (exec)
        begin
            case (cw.acc_op)
                ACC_LOAD:   acc_reg <= ACC_W'(prod_reg);
                ACC_ADD:    acc_reg <= acc_reg + ACC_W'(prod_reg);
                ACC_ADD_HI: acc_reg <= acc_reg + {prod_reg[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
                default: ;
            endcase

            case (cw.op)
                OP_ERR:  err_reg      <= sat_data(err_wide);
                OP_DIFF: diff_neg_reg <= diff_c[DIFF_W-1];
                OP_SAT:  drive64_reg  <= drive64_next;
                OP_PUBLISH:
                begin
                    out_upd_reg      <= upd_pend_reg;
                    out_drive_reg    <= last_drive_reg;
                    out_error_reg    <= last_error_reg;
                    out_integral_reg <= integral_reg;
                    out_deriv_reg    <= last_deriv_reg;
                end
                default: ;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign updated        = out_upd_reg;
    assign drive_out      = out_drive_reg;
    assign error_out      = out_error_reg;
    assign integral_out   = out_integral_reg;
    assign derivative_out = out_deriv_reg;

endmodule

### src/pidc_divider.sv
module pidc_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pidc_pkg::DIFF_W-1:0]   dividend,
    input  logic [pidc_pkg::TIME_W-1:0]   divisor,
    output logic                          done,
    output logic [pidc_pkg::DIFF_W-1:0]   quotient
);
    import pidc_pkg::*;

    logic [DIV_CNT_W-1:0] count_reg;
    logic                 done_reg;
    logic [DIFF_W-1:0]    quo_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    dvs_reg;
    logic [TIME_W:0]      rem_shift;
    logic [TIME_W+1:0]    trial;

    assign rem_shift = {rem_reg, quo_reg[DIFF_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            count_reg <= DIV_CNT_W'(DIFF_W);
            done_reg  <= 1'b0;
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            if (!trial[TIME_W+1])
            begin
                rem_reg <= trial[TIME_W-1:0];
                quo_reg <= {quo_reg[DIFF_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[TIME_W-1:0];
                quo_reg <= {quo_reg[DIFF_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
